[hdl/cri_pkg.sv]
package cri_pkg;

    // Defaults for the top level parameters
    localparam int MAX_LENGTH    = 1024;
    localparam int ALPHABET_SIZE = 256;

    // Fixed field widths
    localparam int CHAR_W    = 8;
    localparam int THRESH_W  = 10;
    localparam int SQ_OUT_W  = 21;
    localparam int LEN_OUT_W = 11;

    // Threshold in thousandths; reset value is 0.3
    localparam logic [THRESH_W-1:0] THRESH_RESET = 10'd300;
    localparam int SCALE = 1000;

    // Fraction bits of the reciprocal used to fold a byte into the alphabet
    localparam int RECIP_SHIFT = 16;

endpackage

[hdl/cri_if.sv]
interface cri_in_if;
    logic                       valid;
    logic                       ready;
    logic [cri_pkg::CHAR_W-1:0] char_code;
    logic                       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface cri_out_if;
    logic                          valid;
    logic                          ready;
    logic                          repetitive;
    logic [cri_pkg::SQ_OUT_W-1:0]  square_sum;
    logic [cri_pkg::LEN_OUT_W-1:0] string_length;
    logic                          length_overflow;

    modport source (output valid, output repetitive, output square_sum,
                    output string_length, output length_overflow, input ready);
    modport sink   (input valid, input repetitive, input square_sum,
                    input string_length, input length_overflow, output ready);
endinterface

[hdl/char_repetition_index.sv]
// Repetition index of a byte string. Bytes arrive one per beat on i_char, the
// final one flagged by last_char; for that final beat the block returns one
// result on o_res: the sum of squared byte counts, the number of bytes counted,
// an overflow flag, and repetitive = 1 when 1000*sum >= threshold*len^2, i.e.
// when the Simpson index reaches threshold_permille/1000 (reset 300). Bytes
// past MAX_LENGTH are dropped and flagged; a byte at or above ALPHABET_SIZE is
// counted modulo ALPHABET_SIZE. Throughput is one byte per clock unless the
// output stalls: the per-byte count lives in a RAM with a registered read, and
// each byte does one read-modify-write, forwarded when neighboring bytes hit
// the same entry. Results then pass the compare stages. The table is
// emptied by a row of valid bits, so there is no clearing pass after reset or
// between strings. Write the threshold only while no string is in flight.
module char_repetition_index #(
    parameter int MAX_LENGTH    = cri_pkg::MAX_LENGTH,
    parameter int ALPHABET_SIZE = cri_pkg::ALPHABET_SIZE
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [cri_pkg::THRESH_W-1:0] i_cfg_wr_data,
    cri_in_if.sink                       i_char,
    cri_out_if.source                    o_res
);

    localparam int CNT_W   = $clog2(MAX_LENGTH + 1);
    localparam int SUM_W   = 2 * CNT_W;
    localparam int IDX_W   = $clog2(ALPHABET_SIZE);
    localparam int RECIP   = ((1 << cri_pkg::RECIP_SHIFT) + ALPHABET_SIZE - 1) / ALPHABET_SIZE;
    localparam int RECIP_W = cri_pkg::RECIP_SHIFT + 1;
    localparam int QP_W    = cri_pkg::CHAR_W + RECIP_W;
    localparam int REM_W   = cri_pkg::CHAR_W + 1;

    // ---------------------------------------------------------------
    // Threshold register
    // ---------------------------------------------------------------
    logic [cri_pkg::THRESH_W-1:0] r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= cri_pkg::THRESH_RESET;
        end else if (i_cfg_wr_en) begin
            r_thr <= i_cfg_wr_data;
        end
    end

    // ---------------------------------------------------------------
    // Global advance: the whole pipe moves unless a result is parked
    // in the output register and not taken.
    // ---------------------------------------------------------------
    logic r_out_valid;
    logic w_adv;
    logic w_fire;

    assign w_adv        = ~r_out_valid | o_res.ready;
    assign i_char.ready = w_adv;
    assign w_fire       = i_char.valid & w_adv;

    // ---------------------------------------------------------------
    // Stage 0: fold byte into alphabet, length bookkeeping
    // ---------------------------------------------------------------
    // code mod ALPHABET_SIZE via reciprocal; exact for 8-bit codes
    logic [QP_W-1:0]  w_qprod;
    logic [REM_W-1:0] w_quot;
    logic [REM_W-1:0] w_rem;
    logic [IDX_W-1:0] w_idx;

    assign w_qprod = QP_W'(i_char.char_code) * QP_W'(RECIP);
    assign w_quot  = REM_W'(w_qprod >> cri_pkg::RECIP_SHIFT);
    assign w_rem   = REM_W'(i_char.char_code) - w_quot * REM_W'(ALPHABET_SIZE);
    assign w_idx   = w_rem[IDX_W-1:0];

    logic [CNT_W-1:0] r_len;
    logic             r_ovf;
    logic             w_cnt_en;
    logic [CNT_W-1:0] w_len_new;
    logic             w_ovf_new;

    assign w_cnt_en  = (r_len < CNT_W'(MAX_LENGTH));
    assign w_len_new = r_len + CNT_W'(w_cnt_en);
    assign w_ovf_new = r_ovf | ~w_cnt_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_ovf <= 1'b0;
        end else if (w_fire) begin
            if (i_char.last_char) begin
                r_len <= '0;
                r_ovf <= 1'b0;
            end else begin
                r_len <= w_len_new;
                r_ovf <= w_ovf_new;
            end
        end
    end

    logic             r_s1_valid;
    logic [IDX_W-1:0] r_s1_idx;
    logic             r_s1_last;
    logic             r_s1_cnt_en;
    logic [CNT_W-1:0] r_s1_len;
    logic             r_s1_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= w_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_s1_idx    <= w_idx;
            r_s1_last   <= i_char.last_char;
            r_s1_cnt_en <= w_cnt_en;
            r_s1_len    <= w_len_new;
            r_s1_ovf    <= w_ovf_new;
        end
    end

    // ---------------------------------------------------------------
    // Count table RAM. While stalled, keep reading the held entry so
    // its data is fresh when the pipe moves again.
    // ---------------------------------------------------------------
    logic             w_wr_en;
    logic [CNT_W-1:0] w_cnt_next;
    logic [IDX_W-1:0] w_rd_addr;
    logic [CNT_W-1:0] w_rd_data;

    assign w_rd_addr = w_adv ? w_idx : r_s1_idx;

    cri_ram #(
        .WIDTH (CNT_W),
        .DEPTH (ALPHABET_SIZE)
    ) u_count_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_s1_idx),
        .i_wr_data (w_cnt_next),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // ---------------------------------------------------------------
    // Stage 1: read-modify-write of the count, running square sum
    // ---------------------------------------------------------------
    logic [ALPHABET_SIZE-1:0] r_tab_vld;   // entry written this string
    logic                     r_fw_valid;  // previous advance's write, for bypass
    logic [IDX_W-1:0]         r_fw_idx;
    logic [CNT_W-1:0]         r_fw_cnt;
    logic [SUM_W-1:0]         r_sum;

    logic             w_s1_go;
    logic             w_fw_hit;
    logic [CNT_W-1:0] w_cur;
    logic [SUM_W-1:0] w_sum_new;

    assign w_s1_go    = r_s1_valid & w_adv;
    assign w_fw_hit   = r_fw_valid && (r_fw_idx == r_s1_idx);
    assign w_cur      = w_fw_hit ? r_fw_cnt :
                        (r_tab_vld[r_s1_idx] ? w_rd_data : '0);
    assign w_cnt_next = w_cur + CNT_W'(1);
    // (c+1)^2 - c^2 = 2c+1
    assign w_sum_new  = r_s1_cnt_en ? r_sum + SUM_W'({w_cur, 1'b1}) : r_sum;
    // the last byte's count is never read again, so it skips the write
    assign w_wr_en    = w_s1_go & r_s1_cnt_en & ~r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= '0;
            r_tab_vld  <= '0;
            r_fw_valid <= 1'b0;
        end else begin
            if (w_s1_go) begin
                r_sum <= r_s1_last ? '0 : w_sum_new;
            end
            if (w_s1_go && r_s1_last) begin
                r_tab_vld <= '0;
            end else if (w_wr_en) begin
                r_tab_vld[r_s1_idx] <= 1'b1;
            end
            if (w_adv) begin
                r_fw_valid <= w_wr_en;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_fw_idx <= r_s1_idx;
            r_fw_cnt <= w_cnt_next;
        end
    end

    // ---------------------------------------------------------------
    // Threshold compare, three stages
    // ---------------------------------------------------------------
    logic             w_j_valid;
    logic             w_j_rep;
    logic [SUM_W-1:0] w_j_sum;
    logic [CNT_W-1:0] w_j_len;
    logic             w_j_ovf;

    cri_judge #(
        .CNT_W (CNT_W)
    ) u_judge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_thr   (r_thr),
        .i_valid (w_s1_go & r_s1_last),
        .i_sum   (w_sum_new),
        .i_len   (r_s1_len),
        .i_ovf   (r_s1_ovf),
        .o_valid (w_j_valid),
        .o_rep   (w_j_rep),
        .o_sum   (w_j_sum),
        .o_len   (w_j_len),
        .o_ovf   (w_j_ovf)
    );

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    logic                          r_out_rep;
    logic [cri_pkg::SQ_OUT_W-1:0]  r_out_sum;
    logic [cri_pkg::LEN_OUT_W-1:0] r_out_len;
    logic                          r_out_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_j_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_j_valid) begin
            r_out_rep <= w_j_rep;
            r_out_sum <= cri_pkg::SQ_OUT_W'(w_j_sum);
            r_out_len <= cri_pkg::LEN_OUT_W'(w_j_len);
            r_out_ovf <= w_j_ovf;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.repetitive      = r_out_rep;
    assign o_res.square_sum      = r_out_sum;
    assign o_res.string_length   = r_out_len;
    assign o_res.length_overflow = r_out_ovf;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_len_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && i_char.last_char |=> r_len == '0)
        else $error("length count not restarted after last beat");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_ovf |-> r_out_len == cri_pkg::LEN_OUT_W'(MAX_LENGTH))
        else $error("overflow reported with short length");

    a_tab_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_go && r_s1_last |=> r_tab_vld == '0)
        else $error("count table not emptied at end of string");

    a_fw_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fw_hit |-> r_tab_vld[r_s1_idx])
        else $error("bypass hit on an entry not written this string");

endmodule

[hdl/cri_ram.sv]
module cri_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // read-first: a same-address write shows up on the next read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/cri_judge.sv]
module cri_judge #(
    parameter int CNT_W = 11,
    localparam int SUM_W = 2 * CNT_W,
    localparam int PW    = 2 * CNT_W + cri_pkg::THRESH_W
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  logic [cri_pkg::THRESH_W-1:0] i_thr,
    input  logic                         i_valid,
    input  logic [SUM_W-1:0]             i_sum,
    input  logic [CNT_W-1:0]             i_len,
    input  logic                         i_ovf,
    output logic                         o_valid,
    output logic                         o_rep,
    output logic [SUM_W-1:0]             o_sum,
    output logic [CNT_W-1:0]             o_len,
    output logic                         o_ovf
);

    logic             r_j1_valid, r_j2_valid, r_j3_valid;
    logic [SUM_W-1:0] r_j1_sum, r_j2_sum, r_j3_sum;
    logic [CNT_W-1:0] r_j1_len, r_j2_len, r_j3_len;
    logic             r_j1_ovf, r_j2_ovf, r_j3_ovf;
    logic [SUM_W-1:0] r_j2_len2;
    logic [PW-1:0]    r_j3_lhs, r_j3_rhs;

    logic [SUM_W-1:0] w_len2;
    logic [PW-1:0]    w_lhs, w_rhs;

    assign w_len2 = SUM_W'(r_j1_len) * SUM_W'(r_j1_len);
    assign w_lhs  = PW'(r_j2_sum) * PW'(cri_pkg::SCALE);
    assign w_rhs  = PW'(i_thr) * PW'(r_j2_len2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j1_valid <= 1'b0;
            r_j2_valid <= 1'b0;
            r_j3_valid <= 1'b0;
        end else if (i_adv) begin
            r_j1_valid <= i_valid;
            r_j2_valid <= r_j1_valid;
            r_j3_valid <= r_j2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_j1_sum  <= i_sum;
            r_j1_len  <= i_len;
            r_j1_ovf  <= i_ovf;
            r_j2_sum  <= r_j1_sum;
            r_j2_len  <= r_j1_len;
            r_j2_ovf  <= r_j1_ovf;
            r_j2_len2 <= w_len2;
            r_j3_sum  <= r_j2_sum;
            r_j3_len  <= r_j2_len;
            r_j3_ovf  <= r_j2_ovf;
            r_j3_lhs  <= w_lhs;
            r_j3_rhs  <= w_rhs;
        end
    end

    assign o_valid = r_j3_valid;
    assign o_rep   = (r_j3_lhs >= r_j3_rhs);
    assign o_sum   = r_j3_sum;
    assign o_len   = r_j3_len;
    assign o_ovf   = r_j3_ovf;

endmodule
